// ===== hdl/swdre_pkg.sv =====
// shared constants and codes for the snapshot word diff run encoder
package swdre_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int WORD_BYTES    = 8;
    localparam int WORD_SHIFT    = 3;
    localparam int DATA_BITS     = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int KIND_W        = 2;
    localparam int FIFO_DEPTH    = 4;
    localparam int BUDGET_DIV    = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEW_SIZE     = 2'd0,
        CFG_BASE_SIZE    = 2'd1,
        CFG_BASE_PRESENT = 2'd2
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN      = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_FALLBACK = 2'd2
    } t_kind;

endpackage

// ===== hdl/snapshot_word_diff_run_encoder.sv =====
// snapshot word diff run encoder top level
// Compares a new snapshot against its parent one 64-bit word pair per beat and
// reports each run of differing words as a run beat (byte offset, byte length),
// falling back to a full copy once differing bytes pass a tenth of the parent
// size. A finish beat closes the snapshot with the tail run, if any, and a
// completion beat, or with a fallback beat. One input beat is taken per cycle
// when not stalled; results pass from the input register into a four-entry
// output queue that drains one beat per cycle while the receiver is ready. A
// finish that yields a run and a completion writes two queue entries, so a beat
// held in the input register waits whenever fewer than two entries are free and
// the input stalls once that register is occupied. After reset and after every
// configuration write the input stays stalled while the derived sizes settle.
module snapshot_word_diff_run_encoder
    import swdre_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_BITS-1:0]   i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // new_word, base_word
    input  logic [2*DATA_BITS-1:0] s_axis_tdata,
    // func
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // run_offset, run_bytes, diff_total, zero pad
    output logic [((3*SIZE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
    // kind
    output logic [KIND_W-1:0]      m_axis_tuser,
    // final_flag
    output logic                   m_axis_tlast
);

    localparam int PAY_W   = 3 * SIZE_BITS + 1;
    localparam int OUT_W   = ((PAY_W + 7) / 8) * 8;
    localparam int ENTRY_W = PAY_W + KIND_W + 1;

    logic [SIZE_BITS-1:0] base_size;
    logic                 base_present;
    logic [SIZE_BITS-4:0] main_words;
    logic [SIZE_BITS-1:0] main_bytes;
    logic [SIZE_BITS-1:0] tail;
    logic [SIZE_BITS+3:0] tail10;
    logic                 cfg_busy;
    logic                 space;
    logic                 push0;
    logic                 push1;
    logic [ENTRY_W-1:0]   entry0;
    logic [ENTRY_W-1:0]   entry1;
    logic [ENTRY_W-1:0]   head;

    swdre_cfg #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_base_size    (base_size),
        .o_base_present (base_present),
        .o_main_words   (main_words),
        .o_main_bytes   (main_bytes),
        .o_tail         (tail),
        .o_tail10       (tail10),
        .o_busy         (cfg_busy)
    );

    swdre_core #(
        .SIZE_BITS (SIZE_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser[0]),
        .i_new_word     (s_axis_tdata[DATA_BITS-1:0]),
        .i_base_word    (s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
        .i_base_size    (base_size),
        .i_base_present (base_present),
        .i_main_words   (main_words),
        .i_main_bytes   (main_bytes),
        .i_tail         (tail),
        .i_tail10       (tail10),
        .i_cfg_busy     (cfg_busy),
        .i_space        (space),
        .o_push0        (push0),
        .o_push1        (push1),
        .o_entry0       (entry0),
        .o_entry1       (entry1)
    );

    swdre_fifo #(
        .DATA_W (ENTRY_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_push1 (push1),
        .i_data0 (entry0),
        .i_data1 (entry1),
        .o_free2 (space),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (head)
    );

    assign m_axis_tdata = OUT_W'(head[PAY_W-1:0]);
    assign m_axis_tuser = head[PAY_W+KIND_W-1:PAY_W];
    assign m_axis_tlast = head[ENTRY_W-1];

endmodule

// ===== hdl/swdre_cfg.sv =====
// configuration registers and the sizes derived from them
module swdre_cfg
    import swdre_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_BITS-1:0]   i_cfg_data,
    output logic [SIZE_BITS-1:0]   o_base_size,
    output logic                   o_base_present,
    output logic [SIZE_BITS-4:0]   o_main_words,
    output logic [SIZE_BITS-1:0]   o_main_bytes,
    output logic [SIZE_BITS-1:0]   o_tail,
    output logic [SIZE_BITS+3:0]   o_tail10,
    output logic                   o_busy
);

    logic [SIZE_BITS-1:0] r_new_size;
    logic [SIZE_BITS-1:0] r_base_size;
    logic                 r_base_present;
    logic [1:0]           r_busy;
    logic [SIZE_BITS-1:0] r_cmp;
    logic [SIZE_BITS-1:0] r_grow;
    logic [SIZE_BITS-1:0] r_tail;
    logic [SIZE_BITS-1:0] r_main_bytes;
    logic [SIZE_BITS-4:0] r_main_words;
    logic [SIZE_BITS+3:0] r_tail10;
    logic [SIZE_BITS+3:0] n_tail_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_new_size     <= '0;
            r_base_size    <= '0;
            r_base_present <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NEW_SIZE:     r_new_size     <= i_cfg_data;
                CFG_BASE_SIZE:    r_base_size    <= i_cfg_data;
                CFG_BASE_PRESENT: r_base_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // derived sizes pass through registers, intake waits for them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 2'd2;
        end else if (i_cfg_wr_en) begin
            r_busy <= 2'd2;
        end else if (r_busy != 2'd0) begin
            r_busy <= r_busy - 2'd1;
        end
    end

    assign n_tail_ext = {4'b0, r_tail};

    always_ff @(posedge i_clk) begin
        r_cmp        <= (r_new_size < r_base_size) ? r_new_size : r_base_size;
        r_grow       <= (r_new_size > r_base_size) ? (r_new_size - r_base_size) : '0;
        r_tail       <= {{(SIZE_BITS-WORD_SHIFT){1'b0}}, r_cmp[WORD_SHIFT-1:0]} + r_grow;
        r_main_bytes <= {r_cmp[SIZE_BITS-1:WORD_SHIFT], {WORD_SHIFT{1'b0}}};
        r_main_words <= r_cmp[SIZE_BITS-1:WORD_SHIFT];
        r_tail10     <= (n_tail_ext << 3) + (n_tail_ext << 1);
    end

    assign o_base_size    = r_base_size;
    assign o_base_present = r_base_present;
    assign o_main_words   = r_main_words;
    assign o_main_bytes   = r_main_bytes;
    assign o_tail         = r_tail;
    assign o_tail10       = r_tail10;
    assign o_busy         = (r_busy != 2'd0);

endmodule

// ===== hdl/swdre_fifo.sv =====
// small result queue, up to two writes and one read per cycle
module swdre_fifo
    import swdre_pkg::*;
#(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push0,
    input  logic              i_push1,
    input  logic [DATA_W-1:0] i_data0,
    input  logic [DATA_W-1:0] i_data1,
    output logic              o_free2,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    logic [DATA_W-1:0] r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              n_pop;
    logic [PTR_W-1:0]  n_wr_ptr1;

    assign n_pop     = o_valid && i_ready;
    assign n_wr_ptr1 = r_wr_ptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[n_wr_ptr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push0) + PTR_W'(i_push1);
            r_rd_ptr <= r_rd_ptr + PTR_W'(n_pop);
            r_count  <= r_count + (PTR_W+1)'(i_push0) + (PTR_W+1)'(i_push1)
                        - (PTR_W+1)'(n_pop);
        end
    end

    assign o_free2 = (r_count <= (PTR_W+1)'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

// ===== hdl/swdre_core.sv =====
// input register, run tracking, budget check; one beat per cycle while queue has room and cfg idle
module swdre_core
    import swdre_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    parameter int ENTRY_W   = 3 * SIZE_BITS_DEF + 1 + KIND_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic [DATA_BITS-1:0] i_new_word,
    input  logic [DATA_BITS-1:0] i_base_word,
    input  logic [SIZE_BITS-1:0] i_base_size,
    input  logic                 i_base_present,
    input  logic [SIZE_BITS-4:0] i_main_words,
    input  logic [SIZE_BITS-1:0] i_main_bytes,
    input  logic [SIZE_BITS-1:0] i_tail,
    input  logic [SIZE_BITS+3:0] i_tail10,
    input  logic                 i_cfg_busy,
    input  logic                 i_space,
    output logic                 o_push0,
    output logic                 o_push1,
    output logic [ENTRY_W-1:0]   o_entry0,
    output logic [ENTRY_W-1:0]   o_entry1
);

    localparam int ACC_W   = SIZE_BITS + 1;
    localparam int ACC10_W = SIZE_BITS + 5;
    localparam int WC_W    = SIZE_BITS - WORD_SHIFT;

    function automatic logic [ENTRY_W-1:0] pack_entry(
        input t_kind                kind,
        input logic [SIZE_BITS-1:0] off,
        input logic [SIZE_BITS-1:0] len,
        input logic [ACC_W-1:0]     total,
        input logic                 last
    );
        pack_entry = {last, kind, total, len, off};
    endfunction

    logic                 r_in_vld;
    logic                 r_in_func;
    logic                 r_in_neq;
    logic [WC_W-1:0]      r_wc;
    logic [SIZE_BITS-1:0] r_start;
    logic [SIZE_BITS-1:0] r_len;
    logic [ACC_W-1:0]     r_acc;
    logic [ACC10_W-1:0]   r_acc10;
    logic                 r_gave_up;

    logic [WC_W-1:0]      n_wc;
    logic [SIZE_BITS-1:0] n_start;
    logic [SIZE_BITS-1:0] n_len;
    logic [ACC_W-1:0]     n_acc;
    logic [ACC10_W-1:0]   n_acc10;
    logic                 n_gave_up;

    logic                 fire;
    logic                 accept;
    logic [ACC_W-1:0]     acc_w;
    logic [ACC10_W-1:0]   acc10_w;
    logic [ACC_W-1:0]     acc_f;
    logic [ACC10_W-1:0]   acc10_f;
    logic                 over_w;
    logic                 over_f;
    logic                 run_open;
    logic                 skip;
    logic [SIZE_BITS-1:0] fin_len;
    logic [SIZE_BITS-1:0] fin_off;

    assign fire    = r_in_vld && i_space;
    assign o_ready = (!r_in_vld || i_space) && !i_cfg_busy;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_func <= i_func;
            r_in_neq  <= (i_new_word != i_base_word);
        end
    end

    assign acc_w    = r_acc + ACC_W'(WORD_BYTES);
    assign acc10_w  = r_acc10 + ACC10_W'(BUDGET_DIV * WORD_BYTES);
    assign acc_f    = r_acc + {1'b0, i_tail};
    assign acc10_f  = r_acc10 + {1'b0, i_tail10};
    // total > base / 10 is the same test as 10 * total > base
    assign over_w   = acc10_w > {5'b0, i_base_size};
    assign over_f   = acc10_f > {5'b0, i_base_size};
    assign run_open = (r_len != '0);
    assign skip     = r_gave_up || !i_base_present || (r_wc >= i_main_words);
    assign fin_len  = run_open ? (r_len + i_tail) : i_tail;
    assign fin_off  = run_open ? r_start : i_main_bytes;

    always_comb begin
        n_wc      = r_wc;
        n_start   = r_start;
        n_len     = r_len;
        n_acc     = r_acc;
        n_acc10   = r_acc10;
        n_gave_up = r_gave_up;
        o_push0   = 1'b0;
        o_push1   = 1'b0;
        o_entry0  = pack_entry(KIND_DONE, '0, '0, acc_f, 1'b1);
        o_entry1  = pack_entry(KIND_DONE, '0, '0, acc_f, 1'b1);
        if (fire) begin
            if (!r_in_func) begin
                if (!skip) begin
                    n_wc = r_wc + WC_W'(1);
                    if (r_in_neq) begin
                        if (!run_open) begin
                            n_start = {r_wc, {WORD_SHIFT{1'b0}}};
                        end
                        n_len   = r_len + SIZE_BITS'(WORD_BYTES);
                        n_acc   = acc_w;
                        n_acc10 = acc10_w;
                        if (over_w) begin
                            n_gave_up = 1'b1;
                            n_len     = '0;
                            o_push0   = 1'b1;
                            o_entry0  = pack_entry(KIND_FALLBACK, '0, '0, acc_w, 1'b0);
                        end
                    end else if (run_open) begin
                        o_push0  = 1'b1;
                        o_entry0 = pack_entry(KIND_RUN, r_start, r_len, r_acc, 1'b0);
                        n_len    = '0;
                    end
                end
            end else begin
                n_wc      = '0;
                n_start   = '0;
                n_len     = '0;
                n_acc     = '0;
                n_acc10   = '0;
                n_gave_up = 1'b0;
                o_push0   = 1'b1;
                if (!i_base_present || r_gave_up) begin
                    o_entry0 = pack_entry(KIND_FALLBACK, '0, '0, r_acc, 1'b1);
                end else if (over_f) begin
                    o_entry0 = pack_entry(KIND_FALLBACK, '0, '0, acc_f, 1'b1);
                end else if (fin_len != '0) begin
                    o_entry0 = pack_entry(KIND_RUN, fin_off, fin_len, acc_f, 1'b0);
                    o_push1  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc      <= '0;
            r_start   <= '0;
            r_len     <= '0;
            r_acc     <= '0;
            r_acc10   <= '0;
            r_gave_up <= 1'b0;
        end else begin
            r_wc      <= n_wc;
            r_start   <= n_start;
            r_len     <= n_len;
            r_acc     <= n_acc;
            r_acc10   <= n_acc10;
            r_gave_up <= n_gave_up;
        end
    end

endmodule
